### rtl/core/wvsd_pkg.sv
// Shared constants for the window variance stall detector.
// No dependencies; used by every module of the block.
package wvsd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int SAMPLE_W      = 16;
   localparam int STUCK_W       = 16;
   localparam int DIV_W         = 8;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [DIV_W-1:0]   SPREAD_RESET = 8'd5;
   localparam logic [STUCK_W-1:0] STUCK_MAX    = 16'hFFFF;

   // item kinds carried on req_tuser
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_EVAL   = 1'b1;

endpackage

### rtl/core/wvsd_front.sv
// Front end: accepts items, keeps the sample ring and the running sums.
// Hands each item to the queue with a snapshot of the sums. Uses wvsd_pkg.
module wvsd_front #(
   parameter int DEPTH = wvsd_pkg::DEPTH_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic                                              in_func,
   input  logic [wvsd_pkg::SAMPLE_W-1:0]                     in_sample,
   output logic                                              push_valid,
   input  logic                                              push_ready,
   output logic [1+3*wvsd_pkg::SAMPLE_W+2*$clog2(DEPTH)-1:0] push_data
);
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int SUM_W  = wvsd_pkg::SAMPLE_W + SLOT_W;
   localparam int SQ_W   = 2 * wvsd_pkg::SAMPLE_W + SLOT_W;
   localparam int SQR_W  = 2 * wvsd_pkg::SAMPLE_W;

   logic [wvsd_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
   logic [wvsd_pkg::SAMPLE_W-1:0] rd_data_ff;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sumsq_ff, sumsq_in;

   logic                          take;
   logic                          insert;
   logic [wvsd_pkg::SAMPLE_W-1:0] old_sample;
   logic [SQR_W-1:0]              old_sq;
   logic [SQR_W-1:0]              new_sq;

   assign in_ready   = push_ready;
   assign take       = in_valid & push_ready;
   assign insert     = take & (in_func == wvsd_pkg::FUNC_INSERT);
   assign push_valid = in_valid;
   // snapshot taken before this item; only evaluate items use the sums
   assign push_data  = {in_func, sumsq_ff, sum_ff};

   // slots not yet written since reset read as zero; writes go in order
   assign old_sample = wrapped_ff ? rd_data_ff : '0;
   assign old_sq     = SQR_W'(old_sample) * SQR_W'(old_sample);
   assign new_sq     = SQR_W'(in_sample) * SQR_W'(in_sample);

   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      sum_in     = sum_ff;
      sumsq_in   = sumsq_ff;
      if (insert) begin
         if (slot_ff == SLOT_W'(DEPTH - 1)) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
         sum_in   = sum_ff - SUM_W'(old_sample) + SUM_W'(in_sample);
         sumsq_in = sumsq_ff - SQ_W'(old_sq) + SQ_W'(new_sq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
         sumsq_ff   <= '0;
      end else begin
         slot_ff    <= slot_in;
         wrapped_ff <= wrapped_in;
         sum_ff     <= sum_in;
         sumsq_ff   <= sumsq_in;
      end
   end

   // prefetch the next slot to be overwritten; it never collides with the write
   always_ff @(posedge clock) begin
      if (insert) begin
         ring_mem[slot_ff] <= in_sample;
      end
      rd_data_ff <= ring_mem[slot_in];
   end

endmodule

### rtl/core/wvsd_queue.sv
// Short FIFO between the front end and the evaluation pipeline.
// Depth from wvsd_pkg::QUEUE_DEPTH.
module wvsd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = $clog2(wvsd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(wvsd_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [wvsd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(wvsd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(wvsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(wvsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/wvsd_back.sv
// Evaluation pipeline: spread = DEPTH*sumsq - sum^2, compare divisor*spread
// against DEPTH*sum, keep the stuck counter, drive the result register. Uses wvsd_pkg.
module wvsd_back #(
   parameter int DEPTH = wvsd_pkg::DEPTH_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              pop_valid,
   output logic                                              pop_ready,
   input  logic [1+3*wvsd_pkg::SAMPLE_W+2*$clog2(DEPTH)-1:0] pop_data,
   input  logic [wvsd_pkg::DIV_W-1:0]                        spread_divisor,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic [wvsd_pkg::STUCK_W-1:0]                      out_stuck,
   output logic                                              out_moving
);
   localparam int SLOT_W   = $clog2(DEPTH);
   localparam int SUM_W    = wvsd_pkg::SAMPLE_W + SLOT_W;
   localparam int SQ_W     = 2 * wvsd_pkg::SAMPLE_W + SLOT_W;
   localparam int SPREAD_W = 2 * SUM_W;
   localparam int RHS_W    = SUM_W + SLOT_W;
   localparam int LHS_W    = SPREAD_W + wvsd_pkg::DIV_W;

   logic [SUM_W-1:0] in_sum;
   logic [SQ_W-1:0]  in_sumsq;
   logic             in_eval;
   logic             adv;

   logic                v1_ff, v2_ff, v3_ff;
   logic                eval1_ff, eval2_ff, eval3_ff;
   logic [SPREAD_W-1:0] sq1_ff, dsq1_ff, spread2_ff;
   logic [RHS_W-1:0]    rhs1_ff, rhs2_ff, rhs3_ff;
   logic [LHS_W-1:0]    lhs3_ff;

   logic                         out_valid_ff;
   logic [wvsd_pkg::STUCK_W-1:0] stuck_ff, stuck_in;
   logic                         moving_ff, moving_in;

   assign {in_eval, in_sumsq, in_sum} = pop_data;

   // whole pipeline moves together; it only halts when the result is held
   assign adv       = !out_valid_ff || out_ready;
   assign pop_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= pop_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eval1_ff   <= (in_eval == wvsd_pkg::FUNC_EVAL);
         sq1_ff     <= SPREAD_W'(in_sum) * SPREAD_W'(in_sum);
         dsq1_ff    <= SPREAD_W'(in_sumsq) * SPREAD_W'(DEPTH);
         rhs1_ff    <= RHS_W'(in_sum) * RHS_W'(DEPTH);

         eval2_ff   <= eval1_ff;
         spread2_ff <= dsq1_ff - sq1_ff;
         rhs2_ff    <= rhs1_ff;

         eval3_ff   <= eval2_ff;
         lhs3_ff    <= LHS_W'(spread_divisor) * LHS_W'(spread2_ff);
         rhs3_ff    <= rhs2_ff;
      end
   end

   always_comb begin
      stuck_in  = stuck_ff;
      moving_in = moving_ff;
      if (adv && v3_ff && eval3_ff) begin
         if (lhs3_ff > LHS_W'(rhs3_ff)) begin
            moving_in = 1'b1;
            stuck_in  = '0;
         end else begin
            moving_in = 1'b0;
            if (stuck_ff != wvsd_pkg::STUCK_MAX) begin
               stuck_in = stuck_ff + 1'b1;
            end
         end
      end
   end

   // counter state doubles as the result register: inserts echo it unchanged
   always_ff @(posedge clock) begin
      if (reset) begin
         stuck_ff  <= '0;
         moving_ff <= 1'b0;
      end else begin
         stuck_ff  <= stuck_in;
         moving_ff <= moving_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_stuck  = stuck_ff;
   assign out_moving = moving_ff;

endmodule

### rtl/core/window_variance_stall_detector_top.sv
// Window variance stall detector, top level.
// Throughput: one item per cycle while the queue has room; held rsp_tready stalls it.
// Result path: queue, then the three-stage spread/compare pipeline and result register.
// Reset (synchronous): ring reads as zero, sums and stuck counter cleared, divisor 5.
// No clearing pass: the ring fills in order, so unwritten slots read as zero.
module window_variance_stall_detector_top #(
   parameter int DEPTH = wvsd_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] stuck_ticks, [16] window_moving, zeros above
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // spread_divisor
);
   localparam int ENTRY_W = 1 + 3 * wvsd_pkg::SAMPLE_W + 2 * $clog2(DEPTH);

   logic [wvsd_pkg::DIV_W-1:0] spread_ff;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   logic [wvsd_pkg::STUCK_W-1:0] stuck;
   logic                         moving;

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_ff <= wvsd_pkg::SPREAD_RESET;
      end else if (csr_wr_en) begin
         spread_ff <= csr_wr_data;
      end
   end

   wvsd_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser[0]),
      .in_sample  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   wvsd_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wvsd_back #(.DEPTH(DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .spread_divisor (spread_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_stuck      (stuck),
      .out_moving     (moving)
   );

   assign rsp_tdata = {7'd0, moving, stuck};

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_variance_stall_detector_top.
// Depends on wvsd_pkg and the top level RTL with its front, queue and back modules.
module tb_top;

   localparam int WINDOW      = wvsd_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 250;

   typedef struct {
      logic        func;
      logic [15:0] sample;
   } sonar_item_type;

   typedef struct {
      logic [15:0] stuck_ticks;
      logic        window_moving;
   } status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] sample
   logic [0:0]  req_tuser = '0;    // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] stuck_ticks, [16] window_moving
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   window_variance_stall_detector_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] ring_copy [WINDOW];
   logic [3:0]  slot_copy     = '0;
   logic [19:0] sum_copy      = '0;
   logic [35:0] sumsq_copy    = '0;
   logic [15:0] stuck_copy    = '0;
   logic        moving_copy   = 1'b0;
   logic [7:0]  divisor_copy  = wvsd_pkg::SPREAD_RESET;

   sonar_item_type pending_items [$];
   status_type     expected_status [$];

   logic        offering = 1'b0;
   logic        offer_func = 1'b0;
   logic [15:0] offer_sample = '0;
   logic        quiet = 1'b0;
   int          fail_count = 0;
   int          checked_count = 0;
   int          cycle_count = 0;

   initial begin
      for (int i = 0; i < WINDOW; i++) ring_copy[i] = '0;
   end

   function automatic int draw_wait(inout int calm_left);
      if (quiet) return 0;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // Updates the window state for one accepted transfer and queues the status it yields.
   function automatic void advance_detector(logic func, logic [15:0] sample);
      longint unsigned old_val, new_val, spread, lhs, rhs;
      status_type st;
      if (func == wvsd_pkg::FUNC_INSERT) begin
         old_val    = ring_copy[slot_copy];
         new_val    = sample;
         sum_copy   = 20'(longint'(sum_copy) - old_val + new_val);
         sumsq_copy = 36'(longint'(sumsq_copy) - old_val * old_val + new_val * new_val);
         ring_copy[slot_copy] = sample;
         slot_copy  = (slot_copy == 4'(WINDOW - 1)) ? '0 : slot_copy + 4'd1;
      end else begin
         spread = longint'(WINDOW) * longint'(sumsq_copy)
                  - longint'(sum_copy) * longint'(sum_copy);
         lhs    = longint'(divisor_copy) * spread;
         rhs    = longint'(WINDOW) * longint'(sum_copy);
         if (lhs > rhs) begin
            moving_copy = 1'b1;
            stuck_copy  = '0;
         end else begin
            moving_copy = 1'b0;
            if (stuck_copy != wvsd_pkg::STUCK_MAX) stuck_copy = stuck_copy + 16'd1;
         end
      end
      st.stuck_ticks   = stuck_copy;
      st.window_moving = moving_copy;
      expected_status.push_back(st);
   endfunction

   // request side driver
   always @(posedge clock) begin : driver
      sonar_item_type next_item;
      static int gap_left = 0;
      static int snd_calm = 0;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_detector(offer_func, offer_sample);
            offering = 1'b0;
            gap_left = draw_wait(snd_calm);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               next_item    = pending_items.pop_front();
               offer_func   = next_item.func;
               offer_sample = next_item.sample;
               offering     = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_tdata  <= offer_sample;
         req_tuser  <= offer_func;
      end
   end

   // result side monitor and checker
   always @(posedge clock) begin : monitor
      status_type want;
      static int stall_left = 0;
      static int rcv_calm = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: result with nothing expected: expected none, actual tdata %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_tdata[15:0] !== want.stuck_ticks) begin
                  $display("%0t: stuck_ticks mismatch: expected %0d, actual %0d",
                           $time, want.stuck_ticks, rsp_tdata[15:0]);
                  fail_count++;
               end
               if (rsp_tdata[16] !== want.window_moving) begin
                  $display("%0t: window_moving mismatch: expected %0b, actual %0b",
                           $time, want.window_moving, rsp_tdata[16]);
                  fail_count++;
               end
            end
            checked_count++;
            stall_left = draw_wait(rcv_calm);
            // long back-pressure so the block fills and stalls its input
            if (checked_count == 300 || checked_count == 1200) stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic add_item(logic func, logic [15:0] sample);
      sonar_item_type it;
      it.func   = func;
      it.sample = sample;
      pending_items.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || offering || expected_status.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_divisor(logic [7:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      divisor_copy = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Bursts of inserts followed by evaluations: noisy, near-threshold and steady windows.
   task automatic queue_random_chunk(int count);
      int made, mode, inserts, base, jit, value;
      made = 0;
      while (made < count) begin
         mode    = $urandom_range(0, 9);
         inserts = $urandom_range(0, 20);
         base    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535 - 64)
                                               : $urandom_range(0, 200);
         jit     = $urandom_range(0, 12);
         for (int i = 0; i < inserts; i++) begin
            if (mode < 2)      value = $urandom_range(0, 65535);
            else if (mode < 7) value = base + $urandom_range(0, jit);
            else               value = base;
            add_item(wvsd_pkg::FUNC_INSERT, 16'(value));
            made++;
         end
         repeat ($urandom_range(1, 3)) begin
            add_item(wvsd_pkg::FUNC_EVAL, 16'($urandom));
            made++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all-zero window never counts as moving; then edge-value inserts and an evaluation
      add_item(wvsd_pkg::FUNC_EVAL, 16'hFFFF);
      add_item(wvsd_pkg::FUNC_EVAL, 16'h0000);
      add_item(wvsd_pkg::FUNC_INSERT, 16'hFFFF);
      add_item(wvsd_pkg::FUNC_EVAL, 16'h0000);
      add_item(wvsd_pkg::FUNC_INSERT, 16'h0000);
      add_item(wvsd_pkg::FUNC_INSERT, 16'h8000);
      add_item(wvsd_pkg::FUNC_INSERT, 16'h7FFF);
      add_item(wvsd_pkg::FUNC_INSERT, 16'h5555);
      add_item(wvsd_pkg::FUNC_INSERT, 16'hAAAA);
      add_item(wvsd_pkg::FUNC_INSERT, 16'h0001);
      add_item(wvsd_pkg::FUNC_INSERT, 16'hFFFE);
      add_item(wvsd_pkg::FUNC_INSERT, 16'h0000);
      add_item(wvsd_pkg::FUNC_EVAL, 16'h5A5A);
      // wrap of the write slot overwrites the first sample
      repeat (8) add_item(wvsd_pkg::FUNC_INSERT, 16'h0001);
      add_item(wvsd_pkg::FUNC_EVAL, 16'hA5A5);
      // zero divisor: window never moving
      write_divisor(8'd0);
      add_item(wvsd_pkg::FUNC_EVAL, 16'h0000);
      add_item(wvsd_pkg::FUNC_EVAL, 16'hFFFF);
      write_divisor(8'd255);
      add_item(wvsd_pkg::FUNC_EVAL, 16'h0000);

      write_divisor(8'd1);
      queue_random_chunk(400);
      write_divisor(8'd255);
      queue_random_chunk(400);
      write_divisor(wvsd_pkg::SPREAD_RESET);
      queue_random_chunk(400);
      write_divisor(8'($urandom_range(2, 254)));
      queue_random_chunk(400);
      write_divisor(8'd0);
      queue_random_chunk(200);
      write_divisor(8'($urandom_range(1, 255)));
      queue_random_chunk(200);

      // steady window keeps the stuck counter climbing back to back, then a spread clears it
      write_divisor(8'd1);
      quiet = 1'b1;
      repeat (WINDOW) add_item(wvsd_pkg::FUNC_INSERT, 16'd1000);
      repeat (200) add_item(wvsd_pkg::FUNC_EVAL, 16'($urandom));
      add_item(wvsd_pkg::FUNC_INSERT, 16'h0000);
      add_item(wvsd_pkg::FUNC_INSERT, 16'hFFFF);
      add_item(wvsd_pkg::FUNC_EVAL, 16'h0000);

      wait_idle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
